// ===== design/ptpsrv_pkg.sv =====
// Package for the PTP PI clock servo: widths, register map, configuration
// struct, sequencer states and datapath control codes.
// No dependencies.
`default_nettype none

package ptpsrv_pkg;

  // Field and datapath widths
  localparam int OFFSET_WIDTH = 48;
  localparam int PPM_WIDTH    = 32;
  localparam int RATIO_W      = 34;
  localparam int RATE_W       = 32;
  localparam int CFG_AW       = 5;
  localparam int CFG_DW       = 32;
  localparam int CNT_W        = 8;
  localparam int SHIFT_W      = 5;
  localparam int MUL_W        = 32;
  localparam int PROD_W       = 2 * MUL_W;
  localparam int K_W          = 44;
  localparam int TOT_W        = 80;
  localparam int TP_W         = TOT_W - MUL_W;
  localparam int TI_W         = 62;
  localparam int SUM_W        = 64;

  // Constants
  localparam logic [19:0]         PPM_SCALE   = 20'd1000000;
  localparam logic [RATIO_W-1:0]  UNITY_RATIO = 34'h1_0000_0000;
  localparam logic [TI_W-1:0]     TI_SAT      = {1'b1, {(TI_W-1){1'b0}}};
  localparam logic [CNT_W-1:0]    CNT_MAX     = '1;
  localparam logic [OFFSET_WIDTH-1:0] OFFSET_MAXPOS = {1'b0, {(OFFSET_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] PPM_MAX =
      (SUM_W'(1) << (PPM_WIDTH - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] PPM_MIN = -PPM_MAX - SUM_W'(1);

  // Register map (word index)
  typedef enum logic [2:0] {
    REG_STEP_EN,
    REG_LOG_INT,
    REG_IGAIN,
    REG_PGAIN,
    REG_THRESH,
    REG_VLIMIT,
    REG_LOWER,
    REG_UPPER
  } reg_idx_e;

  typedef struct packed {
    logic               step_en;
    logic signed [4:0]  log_int;
    logic [31:0]        igain;
    logic [23:0]        pgain;
    logic [31:0]        thresh;
    logic [CNT_W-1:0]   vlimit;
    logic signed [31:0] lower;
    logic signed [31:0] upper;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    step_en: 1'b1,
    log_int: -5'sd3,
    igain:   32'd10307922,
    pgain:   24'd65536,
    thresh:  32'd1000000000,
    vlimit:  8'd6,
    lower:   -32'sd16384000,
    upper:   32'sd16384000
  };

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_EVAL,
    S_MUL_K,
    S_MUL_I,
    S_MUL_LL,
    S_MUL_LH,
    S_MUL_HL,
    S_MUL_HH,
    S_TOT_HH,
    S_ADD_P,
    S_CLAMP,
    S_DONE
  } state_e;

  // Multiplier operand pairs
  typedef enum logic [2:0] {
    MS_NONE,
    MS_K,
    MS_I,
    MS_LL,
    MS_LH,
    MS_HL,
    MS_HH
  } mul_sel_e;

  // Partial product accumulation
  typedef enum logic [1:0] {
    TOT_HOLD,
    TOT_LOAD,
    TOT_ADD_MID,
    TOT_ADD_HIGH
  } tot_op_e;

  typedef struct packed {
    mul_sel_e mul_sel;
    tot_op_e  tot_op;
    logic     eval;
    logic     ld_k;
    logic     ld_ti;
    logic     ld_sum_i;
    logic     ld_sum_p;
    logic     clamp;
  } ctl_t;

endpackage

`default_nettype wire

// ===== design/ptpsrv_cfg.sv =====
// APB-style configuration register file of the PTP PI clock servo.
// Depends on ptpsrv_pkg for the register map and configuration struct.
`default_nettype none

module ptpsrv_cfg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [ptpsrv_pkg::CFG_AW-1:0] paddr,
  input  wire logic [ptpsrv_pkg::CFG_DW-1:0] pwdata,
  output logic      [ptpsrv_pkg::CFG_DW-1:0] prdata,
  output logic                              pready,
  output ptpsrv_pkg::cfg_t                  cfg_o
);

  localparam int CFG_AW_HI = ptpsrv_pkg::CFG_AW - 1;

  ptpsrv_pkg::cfg_t     cfg_q;
  ptpsrv_pkg::reg_idx_e idx;
  logic                 wr_en;

  assign idx    = ptpsrv_pkg::reg_idx_e'(paddr[CFG_AW_HI:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Register writes on the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= ptpsrv_pkg::CFG_RESET;
    end else if (wr_en) begin
      case (idx)
        ptpsrv_pkg::REG_STEP_EN: cfg_q.step_en <= pwdata[0];
        ptpsrv_pkg::REG_LOG_INT: cfg_q.log_int <= $signed(pwdata[4:0]);
        ptpsrv_pkg::REG_IGAIN:   cfg_q.igain   <= pwdata;
        ptpsrv_pkg::REG_PGAIN:   cfg_q.pgain   <= pwdata[23:0];
        ptpsrv_pkg::REG_THRESH:  cfg_q.thresh  <= pwdata;
        ptpsrv_pkg::REG_VLIMIT:  cfg_q.vlimit  <= pwdata[ptpsrv_pkg::CNT_W-1:0];
        ptpsrv_pkg::REG_LOWER:   cfg_q.lower   <= $signed(pwdata);
        ptpsrv_pkg::REG_UPPER:   cfg_q.upper   <= $signed(pwdata);
        default: ;
      endcase
    end
  end

  // Read back; signed fields sign-extended
  always_comb begin
    case (idx)
      ptpsrv_pkg::REG_STEP_EN: prdata = 32'(cfg_q.step_en);
      ptpsrv_pkg::REG_LOG_INT: prdata = 32'($signed(cfg_q.log_int));
      ptpsrv_pkg::REG_IGAIN:   prdata = cfg_q.igain;
      ptpsrv_pkg::REG_PGAIN:   prdata = 32'(cfg_q.pgain);
      ptpsrv_pkg::REG_THRESH:  prdata = cfg_q.thresh;
      ptpsrv_pkg::REG_VLIMIT:  prdata = 32'(cfg_q.vlimit);
      ptpsrv_pkg::REG_LOWER:   prdata = cfg_q.lower;
      ptpsrv_pkg::REG_UPPER:   prdata = cfg_q.upper;
      default:                 prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== design/ptpsrv_mul.sv =====
// Shared 32x32 unsigned multiplier with registered product.
// Depends on ptpsrv_pkg for operand and product widths.
`default_nettype none

module ptpsrv_mul (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic [ptpsrv_pkg::MUL_W-1:0]  a_i,
  input  wire logic [ptpsrv_pkg::MUL_W-1:0]  b_i,
  output logic      [ptpsrv_pkg::PROD_W-1:0] prod_o
);

  logic [ptpsrv_pkg::PROD_W-1:0] prod_q;
  logic [ptpsrv_pkg::PROD_W-1:0] prod_d;

  assign prod_d = ptpsrv_pkg::PROD_W'(a_i) * ptpsrv_pkg::PROD_W'(b_i);
  assign prod_o = prod_q;

  // Product register, loaded when an operand pair is issued
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/ptp_pi_clock_servo.sv =====
// An integrating update runs S_EVAL, the multiply states, S_TOT_HH, S_ADD_P,
// S_CLAMP and S_DONE; a phase violation goes from S_EVAL to S_CLAMP, an ignored
// request from S_EVAL to S_DONE. A new request is taken only in S_IDLE, once the
// last result is delivered. The shared 32x32 multiplier runs six products per
// integrating update. A stalled result holds the sequencer in its last state.
// Reset: asynchronous active low; clears the servo state and loads register defaults.
`default_nettype none

module ptp_pi_clock_servo (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Configuration port
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [ptpsrv_pkg::CFG_AW-1:0]       paddr,
  input  wire logic [ptpsrv_pkg::CFG_DW-1:0]       pwdata,
  output logic      [ptpsrv_pkg::CFG_DW-1:0]       prdata,
  output logic                                     pready,
  // Request channel
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic signed [ptpsrv_pkg::OFFSET_WIDTH-1:0] phase_offset_i,
  input  wire logic [ptpsrv_pkg::RATIO_W-1:0]      rate_ratio_i,
  input  wire logic                                new_set_point_i,
  // Result channel
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic                                     update_valid_o,
  output logic                                     phase_step_valid_o,
  output logic signed [ptpsrv_pkg::OFFSET_WIDTH-1:0] phase_step_o,
  output logic signed [ptpsrv_pkg::RATE_W-1:0]     rate_ppm_o
);

  localparam int OW = ptpsrv_pkg::OFFSET_WIDTH;
  localparam int SW = ptpsrv_pkg::SUM_W;

  ptpsrv_pkg::cfg_t   cfg;
  ptpsrv_pkg::state_e state_q, state_d;
  ptpsrv_pkg::ctl_t   ctl;

  // Configuration registers
  ptpsrv_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Latched request
  logic [OW-1:0]                     off_q;
  logic [ptpsrv_pkg::RATIO_W-1:0]    ratio_q;
  // Servo state
  logic                              pend_q;
  logic [ptpsrv_pkg::CNT_W-1:0]      vcnt_q;
  logic signed [ptpsrv_pkg::PPM_WIDTH-1:0] acc_q;
  // Per-update working registers
  logic                              ign_q, step_q, eneg_q, dneg_q;
  logic [OW-1:0]                     step_val_q;
  logic [ptpsrv_pkg::MUL_W-1:0]      mag_q;
  logic [ptpsrv_pkg::RATIO_W-1:0]    dmag_q;
  logic [ptpsrv_pkg::K_W-1:0]        k_q;
  logic [ptpsrv_pkg::TI_W-1:0]       ti_q;
  logic [ptpsrv_pkg::TOT_W-1:0]      tot_q, tot_d;
  logic signed [SW-1:0]              sum_q;

  logic in_acc, slot_free;
  assign in_ready_o = (state_q == ptpsrv_pkg::S_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;
  assign slot_free  = ~out_valid_o | out_ready_i;

  // Front-end decisions on the latched request
  logic          off_neg, ign, due, take_step, eff_neg, viol, dneg;
  logic [OW-1:0] off_mag, eff_mag, step_val;
  logic [ptpsrv_pkg::CNT_W-1:0] vbase, vcnt_next;
  logic [ptpsrv_pkg::RATIO_W-1:0] dmag;

  always_comb begin
    off_neg   = off_q[OW-1];
    off_mag   = off_neg ? (~off_q + OW'(1)) : off_q;
    ign       = (off_q == '0) && (ratio_q == ptpsrv_pkg::UNITY_RATIO);
    due       = pend_q || (vcnt_q > cfg.vlimit);
    take_step = due & cfg.step_en;
    if (off_neg) begin
      step_val = (off_mag > ptpsrv_pkg::OFFSET_MAXPOS) ? ptpsrv_pkg::OFFSET_MAXPOS : off_mag;
    end else begin
      step_val = ~off_mag + OW'(1);
    end
    eff_mag   = take_step ? '0 : off_mag;
    eff_neg   = take_step ? 1'b0 : off_neg;
    viol      = eff_mag > OW'(cfg.thresh);
    vbase     = due ? '0 : vcnt_q;
    if (viol) begin
      vcnt_next = (vbase == ptpsrv_pkg::CNT_MAX) ? vbase : vbase + 1'b1;
    end else begin
      vcnt_next = '0;
    end
    dneg = (ratio_q < ptpsrv_pkg::UNITY_RATIO);
    dmag = dneg ? (ptpsrv_pkg::UNITY_RATIO - ratio_q) : (ratio_q - ptpsrv_pkg::UNITY_RATIO);
  end

  // Next-state logic
  always_comb begin
    state_d = state_q;
    case (state_q)
      ptpsrv_pkg::S_IDLE:   if (in_valid_i) state_d = ptpsrv_pkg::S_EVAL;
      ptpsrv_pkg::S_EVAL: begin
        if (ign) begin
          state_d = ptpsrv_pkg::S_DONE;
        end else if (viol) begin
          state_d = ptpsrv_pkg::S_CLAMP;
        end else begin
          state_d = ptpsrv_pkg::S_MUL_K;
        end
      end
      ptpsrv_pkg::S_MUL_K:  state_d = ptpsrv_pkg::S_MUL_I;
      ptpsrv_pkg::S_MUL_I:  state_d = ptpsrv_pkg::S_MUL_LL;
      ptpsrv_pkg::S_MUL_LL: state_d = ptpsrv_pkg::S_MUL_LH;
      ptpsrv_pkg::S_MUL_LH: state_d = ptpsrv_pkg::S_MUL_HL;
      ptpsrv_pkg::S_MUL_HL: state_d = ptpsrv_pkg::S_MUL_HH;
      ptpsrv_pkg::S_MUL_HH: state_d = ptpsrv_pkg::S_TOT_HH;
      ptpsrv_pkg::S_TOT_HH: state_d = ptpsrv_pkg::S_ADD_P;
      ptpsrv_pkg::S_ADD_P:  state_d = ptpsrv_pkg::S_CLAMP;
      ptpsrv_pkg::S_CLAMP:  state_d = ptpsrv_pkg::S_DONE;
      ptpsrv_pkg::S_DONE:   if (slot_free) state_d = ptpsrv_pkg::S_IDLE;
      default:              state_d = ptpsrv_pkg::S_IDLE;
    endcase
  end

  // Control decode per state
  always_comb begin
    ctl = '{mul_sel: ptpsrv_pkg::MS_NONE, tot_op: ptpsrv_pkg::TOT_HOLD, default: 1'b0};
    case (state_q)
      ptpsrv_pkg::S_EVAL:   ctl.eval = 1'b1;
      ptpsrv_pkg::S_MUL_K:  ctl.mul_sel = ptpsrv_pkg::MS_K;
      ptpsrv_pkg::S_MUL_I: begin
        ctl.mul_sel = ptpsrv_pkg::MS_I;
        ctl.ld_k    = 1'b1;
      end
      ptpsrv_pkg::S_MUL_LL: begin
        ctl.mul_sel = ptpsrv_pkg::MS_LL;
        ctl.ld_ti   = 1'b1;
      end
      ptpsrv_pkg::S_MUL_LH: begin
        ctl.mul_sel  = ptpsrv_pkg::MS_LH;
        ctl.tot_op   = ptpsrv_pkg::TOT_LOAD;
        ctl.ld_sum_i = 1'b1;
      end
      ptpsrv_pkg::S_MUL_HL: begin
        ctl.mul_sel = ptpsrv_pkg::MS_HL;
        ctl.tot_op  = ptpsrv_pkg::TOT_ADD_MID;
      end
      ptpsrv_pkg::S_MUL_HH: begin
        ctl.mul_sel = ptpsrv_pkg::MS_HH;
        ctl.tot_op  = ptpsrv_pkg::TOT_ADD_MID;
      end
      ptpsrv_pkg::S_TOT_HH: ctl.tot_op   = ptpsrv_pkg::TOT_ADD_HIGH;
      ptpsrv_pkg::S_ADD_P:  ctl.ld_sum_p = 1'b1;
      ptpsrv_pkg::S_CLAMP:  ctl.clamp    = 1'b1;
      default: ;
    endcase
  end

  // Shared multiplier and its operand select
  logic [ptpsrv_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic [ptpsrv_pkg::PROD_W-1:0] prod;

  always_comb begin
    case (ctl.mul_sel)
      ptpsrv_pkg::MS_K: begin
        mul_a = 32'(cfg.pgain);
        mul_b = 32'(ptpsrv_pkg::PPM_SCALE);
      end
      ptpsrv_pkg::MS_I: begin
        mul_a = mag_q;
        mul_b = cfg.igain;
      end
      ptpsrv_pkg::MS_LL: begin
        mul_a = dmag_q[31:0];
        mul_b = k_q[31:0];
      end
      ptpsrv_pkg::MS_LH: begin
        mul_a = dmag_q[31:0];
        mul_b = 32'(k_q[ptpsrv_pkg::K_W-1:32]);
      end
      ptpsrv_pkg::MS_HL: begin
        mul_a = 32'(dmag_q[ptpsrv_pkg::RATIO_W-1:32]);
        mul_b = k_q[31:0];
      end
      ptpsrv_pkg::MS_HH: begin
        mul_a = 32'(dmag_q[ptpsrv_pkg::RATIO_W-1:32]);
        mul_b = 32'(k_q[ptpsrv_pkg::K_W-1:32]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  ptpsrv_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (ctl.mul_sel != ptpsrv_pkg::MS_NONE),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Integral term: shift by 16 + log interval, saturate
  logic [5:0]                      sh_full;
  logic [ptpsrv_pkg::SHIFT_W-1:0]  sh;
  logic [ptpsrv_pkg::PROD_W-1:0]   shifted;
  logic [ptpsrv_pkg::TI_W-1:0]     ti_next;

  assign sh_full = 6'd16 + {cfg.log_int[4], cfg.log_int};
  assign sh      = sh_full[ptpsrv_pkg::SHIFT_W-1:0];
  assign shifted = prod >> sh;
  assign ti_next = (shifted > ptpsrv_pkg::PROD_W'(ptpsrv_pkg::TI_SAT)) ?
                   ptpsrv_pkg::TI_SAT : shifted[ptpsrv_pkg::TI_W-1:0];

  // Proportional partial product accumulation
  always_comb begin
    case (ctl.tot_op)
      ptpsrv_pkg::TOT_LOAD:     tot_d = ptpsrv_pkg::TOT_W'(prod);
      ptpsrv_pkg::TOT_ADD_MID:  tot_d = tot_q + (ptpsrv_pkg::TOT_W'(prod) << 32);
      ptpsrv_pkg::TOT_ADD_HIGH: tot_d = tot_q + (ptpsrv_pkg::TOT_W'(prod) << 64);
      default:                  tot_d = tot_q;
    endcase
  end

  // Accumulator sum and clamp
  logic signed [SW-1:0] acc_ext, ti_ext, tp_ext, lo_ext, hi_ext, c1, c2, c3;
  logic [ptpsrv_pkg::TP_W-1:0] tp;

  always_comb begin
    tp      = tot_q[ptpsrv_pkg::TOT_W-1:32];
    acc_ext = SW'(acc_q);
    ti_ext  = $signed({{(SW-ptpsrv_pkg::TI_W){1'b0}}, ti_q});
    tp_ext  = $signed({{(SW-ptpsrv_pkg::TP_W){1'b0}}, tp});
    lo_ext  = SW'($signed(cfg.lower));
    hi_ext  = SW'($signed(cfg.upper));
    c1      = (sum_q < lo_ext) ? lo_ext : sum_q;
    c2      = (c1 > hi_ext) ? hi_ext : c1;
    if (c2 > ptpsrv_pkg::PPM_MAX) begin
      c3 = ptpsrv_pkg::PPM_MAX;
    end else if (c2 < ptpsrv_pkg::PPM_MIN) begin
      c3 = ptpsrv_pkg::PPM_MIN;
    end else begin
      c3 = c2;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ptpsrv_pkg::S_IDLE;
      pend_q  <= 1'b0;
      vcnt_q  <= '0;
      acc_q   <= '0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        pend_q <= pend_q | new_set_point_i;
      end else if (ctl.eval && !ign && due) begin
        pend_q <= 1'b0;
      end
      if (ctl.eval && !ign) begin
        vcnt_q <= vcnt_next;
      end
      if (ctl.clamp) begin
        acc_q <= ptpsrv_pkg::PPM_WIDTH'(c3);
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      off_q   <= phase_offset_i;
      ratio_q <= rate_ratio_i;
    end
    if (ctl.eval) begin
      ign_q      <= ign;
      step_q     <= take_step & ~ign;
      step_val_q <= step_val;
      eneg_q     <= eff_neg;
      mag_q      <= eff_mag[ptpsrv_pkg::MUL_W-1:0];
      dneg_q     <= dneg;
      dmag_q     <= dmag;
      sum_q      <= acc_ext;
    end
    if (ctl.ld_k) begin
      k_q <= prod[ptpsrv_pkg::K_W-1:0];
    end
    if (ctl.ld_ti) begin
      ti_q <= ti_next;
    end
    tot_q <= tot_d;
    // phase error is minus the offset
    if (ctl.ld_sum_i) begin
      sum_q <= eneg_q ? (acc_ext + ti_ext) : (acc_ext - ti_ext);
    end else if (ctl.ld_sum_p) begin
      sum_q <= dneg_q ? (sum_q - tp_ext) : (sum_q + tp_ext);
    end
  end

  // Result register
  logic deliver;
  assign deliver = (state_q == ptpsrv_pkg::S_DONE) && slot_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (deliver) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (deliver) begin
      update_valid_o     <= ~ign_q;
      phase_step_valid_o <= step_q;
      phase_step_o       <= step_q ? $signed(step_val_q) : '0;
      rate_ppm_o         <= ign_q ? '0 : ptpsrv_pkg::RATE_W'(acc_q);
    end
  end

`ifndef SYNTH
  a_step_implies_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && phase_step_valid_o |-> update_valid_o)
    else $error("phase step on an ignored request");

  a_ignored_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !update_valid_o |->
      !phase_step_valid_o && phase_step_o == '0 && rate_ppm_o == '0)
    else $error("ignored request carries nonzero result");

  a_clamp_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ptpsrv_pkg::S_CLAMP |=> acc_q <= $past(cfg.upper))
    else $error("accumulator above upper limit after clamp");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after accepting a request");
`endif

endmodule

`default_nettype wire
